### src/tls_record_deframer_defines.svh
// ----------------------------------------------------------------------------
// TLS record deframer assertion macros
// Clocked assertion wrappers; they are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TLS_RECORD_DEFRAMER_DEFINES_SVH
`define TLS_RECORD_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge outside reset.
`define TLS_RD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tls_rd assertion failed");
// Check prop on every rising edge, reset included.
`define TLS_RD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tls_rd assertion failed");
`else
`define TLS_RD_ASSERT(lbl, clk, rst, prop)
`define TLS_RD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### src/tls_rd_pkg.sv
// ----------------------------------------------------------------------------
// TLS record deframer package
// Shared types, codes and reset values of the deframer.
// ----------------------------------------------------------------------------
package tls_rd_pkg;

  localparam logic [7:0] TYPE_RESET    = 8'h17;
  localparam logic [7:0] VERSION_RESET = 8'h03;
  localparam int unsigned CFG_IDX_W    = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPE    = 2'd0,
    CFG_VERSION = 2'd1
  } cfg_idx_t;

  // Position inside the five-byte header, then payload
  typedef enum logic [2:0] {
    POS_TYPE    = 3'd0,
    POS_VER1    = 3'd1,
    POS_VER2    = 3'd2,
    POS_LEN_HI  = 3'd3,
    POS_LEN_LO  = 3'd4,
    POS_PAYLOAD = 3'd5
  } hdr_pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       resync;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expected_type;
    logic [7:0] expected_version;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] record_byte;
    logic       first_of_record;
    logic       last_of_record;
    logic       corrupt;
  } step_t;

endpackage

### src/tls_rd_ifs.sv
// ----------------------------------------------------------------------------
// TLS record deframer channels
// Valid/ready channels for input bytes, record bytes and register writes.
// ----------------------------------------------------------------------------
interface tls_rd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       resync;

  modport source (output valid, output data_byte, output resync, input ready);
  modport sink (input valid, input data_byte, input resync, output ready);
endinterface

interface tls_rd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       first_of_record;
  logic       last_of_record;
  logic       corrupt;

  modport source (output valid, output record_byte, output first_of_record,
                  output last_of_record, output corrupt, input ready);
  modport sink (input valid, input record_byte, input first_of_record,
                input last_of_record, input corrupt, output ready);
endinterface

interface tls_rd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tls_rd_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/tls_record_deframer.sv
// ----------------------------------------------------------------------------
// TLS record deframer
// Cuts a byte stream into TLS records and checks each record header.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one stream byte per item with a resync flag; rec_out
//   carries one result per passed byte: the byte with first/last record
//   marks, or a single corrupt result when a header check fails. cfg writes
//   expected_type (index 0) and expected_version (index 1); it is always
//   ready and should be written only while the block is idle.
//   An accepted item lands in the input register; the parser then runs the
//   header/payload tracking on it and loads the result register, from
//   which the result is offered. One item per cycle is sustained while
//   rec_out does not stall, set by the single parser step per byte.
//   While in error, bytes without resync are dropped and give no result.
//   Reset clears the parser state and restores the register defaults
//   (type 0x17, version 0x03); no clearing pass is needed.
//   When rec_out stalls, the result register holds, the input register
//   fills, and byte_in.ready falls until the receiver takes the result.
// ----------------------------------------------------------------------------
module tls_record_deframer
  import tls_rd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tls_rd_in_if.sink    byte_in,
  tls_rd_out_if.source rec_out,
  tls_rd_cfg_if.sink   cfg
);

  cfg_t     cfg_vals;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     out_free;
  step_t    step;

  tls_rd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_vals (cfg_vals)
  );

  tls_rd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tls_rd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .cfg_vals   (cfg_vals),
    .advance    (advance),
    .step       (step)
  );

  tls_rd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .step     (step),
    .out_free (out_free),
    .rec_out  (rec_out)
  );

endmodule

### src/tls_rd_cfg_regs.sv
// ----------------------------------------------------------------------------
// TLS record deframer configuration registers
// Holds the expected content type and version bytes.
// ----------------------------------------------------------------------------
module tls_rd_cfg_regs
  import tls_rd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tls_rd_cfg_if.sink   cfg,
  output cfg_t         cfg_vals
);

  logic [7:0] expected_type;
  logic [7:0] expected_version;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type    <= TYPE_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_TYPE:    expected_type    <= cfg.data;
        CFG_VERSION: expected_version <= cfg.data;
        default: ;  // unused index: ignore write
      endcase
    end
  end

  assign cfg_vals.expected_type    = expected_type;
  assign cfg_vals.expected_version = expected_version;

endmodule

### src/tls_rd_in_stage.sv
// ----------------------------------------------------------------------------
// TLS record deframer input stage
// Registers one input item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module tls_rd_in_stage
  import tls_rd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tls_rd_in_if.sink   byte_in,
  input  logic        advance,
  output logic        item_valid,
  output in_item_t    item
);

  logic accept;

  assign byte_in.ready = !item_valid || advance;
  assign accept        = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte <= byte_in.data_byte;
      item.resync    <= byte_in.resync;
    end
  end

endmodule

### src/tls_rd_parser.sv
// ----------------------------------------------------------------------------
// TLS record deframer parser
// Tracks header position and payload count; decides the result per byte.
// ----------------------------------------------------------------------------
`include "tls_record_deframer_defines.svh"

module tls_rd_parser
  import tls_rd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  in_item_t item,
  input  logic     out_free,
  input  cfg_t     cfg_vals,
  output logic     advance,
  output step_t    step
);

  hdr_pos_t    pos, pos_next, pos_cur;
  logic [7:0]  length_high, length_high_next, len_hi_cur;
  logic [15:0] payload_left, payload_left_next, left_cur;
  logic        in_error, in_error_next, err_cur;
  logic [15:0] full_len;

  assign advance = item_valid && out_free;

  always_comb begin
    // resync clears the error and any partial record first
    pos_cur    = item.resync ? POS_TYPE : pos;
    len_hi_cur = item.resync ? 8'd0 : length_high;
    left_cur   = item.resync ? 16'd0 : payload_left;
    err_cur    = item.resync ? 1'b0 : in_error;
    full_len   = {len_hi_cur, item.data_byte};

    pos_next          = pos_cur;
    length_high_next  = len_hi_cur;
    payload_left_next = left_cur;
    in_error_next     = err_cur;

    step.emit            = !err_cur;
    step.record_byte     = item.data_byte;
    step.first_of_record = 1'b0;
    step.last_of_record  = 1'b0;
    step.corrupt         = 1'b0;

    if (!err_cur) begin
      unique case (pos_cur)
        POS_TYPE: begin
          step.first_of_record = 1'b1;
          pos_next             = POS_VER1;
          if (item.data_byte != cfg_vals.expected_type) begin
            step.corrupt = 1'b1;
          end
        end
        POS_VER1, POS_VER2: begin
          pos_next = (pos_cur == POS_VER1) ? POS_VER2 : POS_LEN_HI;
          if (item.data_byte != cfg_vals.expected_version) begin
            step.corrupt = 1'b1;
          end
        end
        POS_LEN_HI: begin
          length_high_next = item.data_byte;
          pos_next         = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          payload_left_next = full_len;
          if (full_len == 16'd0) begin
            step.last_of_record = 1'b1;
            pos_next            = POS_TYPE;
          end else begin
            pos_next = POS_PAYLOAD;
          end
        end
        default: begin
          // payload, or an unused code: end the record when nothing is left
          if (left_cur > 16'd1) begin
            payload_left_next = left_cur - 16'd1;
            pos_next          = POS_PAYLOAD;
          end else begin
            payload_left_next   = 16'd0;
            pos_next            = POS_TYPE;
            step.last_of_record = 1'b1;
          end
        end
      endcase

      // header mismatch: drop marks, enter error
      if (step.corrupt) begin
        step.record_byte     = 8'd0;
        step.first_of_record = 1'b0;
        step.last_of_record  = 1'b0;
        pos_next             = POS_TYPE;
        payload_left_next    = 16'd0;
        in_error_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_TYPE;
      length_high  <= 8'd0;
      payload_left <= 16'd0;
      in_error     <= 1'b0;
    end else if (advance) begin
      pos          <= pos_next;
      length_high  <= length_high_next;
      payload_left <= payload_left_next;
      in_error     <= in_error_next;
    end
  end

  `TLS_RD_ASSERT(a_corrupt_sets_error, clk, rst, (advance && step.corrupt) |=> in_error)
  `TLS_RD_ASSERT_ALWAYS(a_payload_nonzero, clk, (pos == POS_PAYLOAD) |-> (payload_left != 16'd0))
  `TLS_RD_ASSERT_ALWAYS(a_error_clean, clk, in_error |-> (pos == POS_TYPE && payload_left == 16'd0))
  `TLS_RD_ASSERT(a_error_drops, clk, rst, (item_valid && in_error && !item.resync) |-> !step.emit)

endmodule

### src/tls_rd_out_stage.sv
// ----------------------------------------------------------------------------
// TLS record deframer output stage
// Result register that holds a record byte until the receiver takes it.
// ----------------------------------------------------------------------------
`include "tls_record_deframer_defines.svh"

module tls_rd_out_stage
  import tls_rd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  step_t        step,
  output logic         out_free,
  tls_rd_out_if.source rec_out
);

  logic  valid;
  logic  load;
  step_t held;

  assign out_free = !valid || rec_out.ready;
  assign load     = advance && step.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rec_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= step;
    end
  end

  assign rec_out.valid           = valid;
  assign rec_out.record_byte     = held.record_byte;
  assign rec_out.first_of_record = held.first_of_record;
  assign rec_out.last_of_record  = held.last_of_record;
  assign rec_out.corrupt         = held.corrupt;

  `TLS_RD_ASSERT(a_load_shows, clk, rst, load |=> valid)
  `TLS_RD_ASSERT(a_no_overwrite, clk, rst, load |-> out_free)

endmodule

### tb/sv/tb_tls_record_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS record deframer testbench
// Walks a table of header, payload, error and resync cases, then streams
// random records under several header settings with random gaps on both
// sides. Each result is checked against the table or a built-in deframing model.
// ----------------------------------------------------------------------------
module tb_tls_record_deframer;
  import tls_rd_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 5;
  localparam int SETTLE_CYC  = 4;
  localparam int TAIL_CYC    = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [7:0] record_byte;
    logic       first_of_record;
    logic       last_of_record;
    logic       corrupt;
  } rec_result_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        resync;
    logic        typed;
    logic        has_result;
    rec_result_t result;
  } dir_row_t;

  localparam rec_result_t BAD_HDR = '{8'h00, 1'b0, 1'b0, 1'b1};
  localparam rec_result_t NO_REC  = '0;

  localparam int DIR_N = 27;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // plain record with reset header values, two payload bytes
    '{8'h17, 1'b0, 1'b1, 1'b1, '{8'h17, 1'b1, 1'b0, 1'b0}},
    '{8'h03, 1'b0, 1'b1, 1'b1, '{8'h03, 1'b0, 1'b0, 1'b0}},
    '{8'h03, 1'b0, 1'b1, 1'b1, '{8'h03, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h02, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'hAA, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
    // zero-length record ends on the low length byte
    '{8'h17, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    // wrong type byte, then bytes dropped while in error
    '{8'h00, 1'b0, 1'b1, 1'b1, BAD_HDR},
    '{8'h17, 1'b0, 1'b1, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_REC},
    // resync, then wrong first version byte
    '{8'h17, 1'b1, 1'b1, 1'b1, '{8'h17, 1'b1, 1'b0, 1'b0}},
    '{8'hFC, 1'b0, 1'b1, 1'b1, BAD_HDR},
    // resync, then wrong second version byte
    '{8'h17, 1'b1, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h04, 1'b0, 1'b1, 1'b1, BAD_HDR},
    // maximum length, cut short by a resync in the payload
    '{8'h17, 1'b1, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h03, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h55, 1'b0, 1'b0, 1'b0, NO_REC},
    '{8'h17, 1'b1, 1'b0, 1'b0, NO_REC}
  };

  logic clk = 1'b0;
  logic rst;

  tls_rd_in_if  byte_if ();
  tls_rd_out_if rec_if ();
  tls_rd_cfg_if cfg_if ();

  tls_record_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_if),
    .rec_out (rec_if),
    .cfg     (cfg_if)
  );

  always #6 clk = ~clk;

  // Deframer model state and header settings
  hdr_pos_t    hdr_pos;
  logic [7:0]  len_hi;
  logic [15:0] left_bytes;
  logic        stuck;
  logic [7:0]  want_type;
  logic [7:0]  want_ver;

  rec_result_t due_results [$];
  int          fed_count;
  int          fault_count;
  int          stall_cycles;
  bit          calm;

  function automatic void frame_byte(input logic [7:0] b, input logic rs,
                                     output logic got, output rec_result_t r);
    logic bad;
    bad = 1'b0;
    got = 1'b1;
    r = '0;
    if (rs) begin
      stuck = 1'b0;
      hdr_pos = POS_TYPE;
      len_hi = '0;
      left_bytes = '0;
    end
    if (stuck) begin
      got = 1'b0;
      return;
    end
    r.record_byte = b;
    case (hdr_pos)
      POS_TYPE: begin
        bad = (b != want_type);
        r.first_of_record = 1'b1;
        hdr_pos = POS_VER1;
      end
      POS_VER1, POS_VER2: begin
        bad = (b != want_ver);
        hdr_pos = (hdr_pos == POS_VER1) ? POS_VER2 : POS_LEN_HI;
      end
      POS_LEN_HI: begin
        len_hi = b;
        hdr_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        left_bytes = {len_hi, b};
        if (left_bytes == 16'd0) begin
          hdr_pos = POS_TYPE;
          r.last_of_record = 1'b1;
        end else begin
          hdr_pos = POS_PAYLOAD;
        end
      end
      default: begin
        if (left_bytes > 16'd1) begin
          left_bytes = left_bytes - 16'd1;
          hdr_pos = POS_PAYLOAD;
        end else begin
          left_bytes = '0;
          hdr_pos = POS_TYPE;
          r.last_of_record = 1'b1;
        end
      end
    endcase
    if (bad) begin
      stuck = 1'b1;
      hdr_pos = POS_TYPE;
      left_bytes = '0;
      r = BAD_HDR;
    end
  endfunction

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Receiver: random stalls, compare each result with the oldest expectation
  always @(posedge clk) begin
    rec_result_t want;
    if (rst) begin
      rec_if.ready <= 1'b0;
    end else begin
      rec_if.ready <= calm || ($urandom_range(99) >= 28);
      if (rec_if.valid && rec_if.ready) begin
        if (due_results.size() == 0) begin
          note_fault($sformatf("unexpected result byte %02h first %0b last %0b corrupt %0b",
                               rec_if.record_byte, rec_if.first_of_record,
                               rec_if.last_of_record, rec_if.corrupt));
        end else begin
          want = due_results.pop_front();
          if (rec_if.record_byte !== want.record_byte ||
              rec_if.first_of_record !== want.first_of_record ||
              rec_if.last_of_record !== want.last_of_record ||
              rec_if.corrupt !== want.corrupt)
            note_fault($sformatf({"expected byte %02h first %0b last %0b corrupt %0b, ",
                                  "got byte %02h first %0b last %0b corrupt %0b"},
                                 want.record_byte, want.first_of_record,
                                 want.last_of_record, want.corrupt,
                                 rec_if.record_byte, rec_if.first_of_record,
                                 rec_if.last_of_record, rec_if.corrupt));
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if ((byte_if.valid && byte_if.ready) || (rec_if.valid && rec_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while (!calm && $urandom_range(99) < 28) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.resync    <= rs;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  task automatic stream_byte(input logic [7:0] b, input logic rs);
    logic        got;
    rec_result_t r;
    send_byte(b, rs);
    frame_byte(b, rs, got, r);
    if (got) begin
      due_results.push_back(r);
      fed_count++;
    end
  endtask

  // Hold the input idle until every result is in and the pipe is empty
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_TYPE:    want_type = val;
      CFG_VERSION: want_ver = val;
      default: ;
    endcase
  endtask

  // One record; bad_at >= 0 corrupts that header byte
  task automatic put_record(input int bad_at);
    logic [7:0]  hdr [5];
    logic [15:0] len;
    logic        rs;
    bit          big;
    int          n_pay;
    big = ($urandom_range(15) == 0);
    len = big ? 16'($urandom) : 16'($urandom_range(12));
    hdr[0] = want_type;
    hdr[1] = want_ver;
    hdr[2] = want_ver;
    hdr[3] = len[15:8];
    hdr[4] = len[7:0];
    if (bad_at >= 0)
      hdr[bad_at] = hdr[bad_at] ^ 8'($urandom_range(1, 255));
    // start clean when in error or mid-record, sometimes anyway
    rs = stuck || (hdr_pos != POS_TYPE) || ($urandom_range(9) == 0);
    for (int i = 0; i < 5; i++)
      stream_byte(hdr[i], (i == 0) ? rs : 1'b0);
    if (bad_at < 0) begin
      n_pay = big ? $urandom_range(8) : int'(len);
      for (int i = 0; i < n_pay; i++)
        stream_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic run_phase(input int n_items);
    int k;
    int n;
    fed_count = 0;
    while (fed_count < n_items) begin
      k = $urandom_range(99);
      if (k < 70) begin
        put_record(-1);
      end else if (k < 82) begin
        put_record($urandom_range(2));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) stream_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    logic        got;
    rec_result_t r;
    dir_row_t    row;
    logic [7:0]  set_type;
    logic [7:0]  set_ver;

    rst               <= 1'b1;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.resync    <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_TYPE;
    cfg_if.data       <= '0;
    hdr_pos      = POS_TYPE;
    len_hi       = '0;
    left_bytes   = '0;
    stuck        = 1'b0;
    want_type    = TYPE_RESET;
    want_ver     = VERSION_RESET;
    fault_count  = 0;
    stall_cycles = 0;
    calm         = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      send_byte(row.data_byte, row.resync);
      frame_byte(row.data_byte, row.resync, got, r);
      if (row.typed) begin
        got = row.has_result;
        r = row.result;
      end
      if (got)
        due_results.push_back(r);
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin set_type = 8'h00; set_ver = 8'h00; end
        1: begin set_type = 8'hFF; set_ver = 8'hFF; end
        4: begin set_type = TYPE_RESET; set_ver = VERSION_RESET; end
        default: begin
          set_type = 8'($urandom_range(255));
          set_ver = 8'($urandom_range(255));
        end
      endcase
      write_reg(CFG_TYPE, set_type);
      write_reg(CFG_VERSION, set_ver);
      // a write past the register list must change nothing
      if (p == 2)
        write_reg(CFG_SPARE, 8'($urandom_range(255)));
      cfg_if.valid <= 1'b0;
      calm = (p == 1);
      run_phase(PHASE_ITEMS);
      settle();
    end
    calm = 1'b0;

    repeat (TAIL_CYC) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
